// ===== hdl/sba_pkg.sv =====
// ----------------------------------------------------------------------------
// sba_pkg
// Widths, register indexes, reset values and shared helpers of the spectrum
// bin attack/release averager.
// ----------------------------------------------------------------------------
package sba_pkg;

  localparam int BIN_W       = 12;
  localparam int CPLX_W      = 32;
  localparam int SQ_W        = 2 * CPLX_W;
  localparam int LEVEL_W     = 48;
  localparam int SHIFT_W     = 6;
  localparam int ALPHA_W     = 16;
  localparam int PROD_W      = LEVEL_W + ALPHA_W + 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int DEFAULT_BINS = 4096;

  localparam logic [CFG_INDEX_W-1:0] REG_POWER_SHIFT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ATTACK_ALPHA  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_ALPHA = 2'd2;

  localparam logic [SHIFT_W-1:0] POWER_SHIFT_RESET   = 6'd22;
  localparam logic [ALPHA_W-1:0] ATTACK_ALPHA_RESET  = 16'd5767;
  localparam logic [ALPHA_W-1:0] RELEASE_ALPHA_RESET = 16'd210;
  localparam logic [LEVEL_W-1:0] LEVEL_FLOOR         = 48'd1;

  // register loads of the pipeline, one per stage
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
    logic ld5;
    logic ld6;
    logic ld_out;
  } sba_load_t;

  function automatic logic [CPLX_W-1:0] abs_mag(input logic signed [CPLX_W-1:0] v);
    logic [CPLX_W-1:0] u;
    u = unsigned'(v);
    return v[CPLX_W-1] ? (~u + CPLX_W'(1)) : u;
  endfunction

endpackage

// ===== hdl/sba_if.sv =====
// ----------------------------------------------------------------------------
// sba_bin_if / sba_level_if
// Valid/ready channels carrying FFT bins in and smoothed bin levels out.
// ----------------------------------------------------------------------------
interface sba_bin_if import sba_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [BIN_W-1:0]         bin_index;
  logic signed [CPLX_W-1:0] real_part;
  logic signed [CPLX_W-1:0] imag_part;

  modport source (output valid, output bin_index, output real_part, output imag_part,
                  input ready);
  modport sink   (input valid, input bin_index, input real_part, input imag_part,
                  output ready);
endinterface

interface sba_level_if import sba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BIN_W-1:0]   out_bin;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output out_bin, output level, input ready);
  modport sink   (input valid, input out_bin, input level, output ready);
endinterface

// ===== hdl/sba_level_ram.sv =====
// ----------------------------------------------------------------------------
// sba_level_ram
// Level store: one write port, one registered read port, write-first on a
// read of the address being written.
// ----------------------------------------------------------------------------
module sba_level_ram import sba_pkg::*; #(
  parameter int DEPTH = DEFAULT_BINS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [LEVEL_W-1:0]       wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [LEVEL_W-1:0]       rdata
);

  logic [LEVEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

endmodule

// ===== hdl/sba_power.sv =====
// ----------------------------------------------------------------------------
// sba_power
// Bin power pipeline: magnitudes, squares, sum, then scale and saturate.
// ----------------------------------------------------------------------------
module sba_power import sba_pkg::*; (
  input  logic                     clk,
  input  sba_load_t                ld,
  input  logic signed [CPLX_W-1:0] real_part,
  input  logic signed [CPLX_W-1:0] imag_part,
  input  logic [SHIFT_W-1:0]       power_shift,
  output logic [LEVEL_W-1:0]       power
);

  logic [CPLX_W-1:0] mag_re;
  logic [CPLX_W-1:0] mag_im;
  logic [SQ_W-1:0]   sq_re;
  logic [SQ_W-1:0]   sq_im;
  logic [SQ_W-1:0]   sq_sum;
  logic [SQ_W-1:0]   scaled;
  logic [LEVEL_W-1:0] power_next;

  assign scaled     = sq_sum >> power_shift;
  assign power_next = (|scaled[SQ_W-1:LEVEL_W]) ? '1 : scaled[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      mag_re <= abs_mag(real_part);
      mag_im <= abs_mag(imag_part);
    end
    if (ld.ld2) begin
      sq_re <= SQ_W'(mag_re) * SQ_W'(mag_re);
      sq_im <= SQ_W'(mag_im) * SQ_W'(mag_im);
    end
    if (ld.ld3) begin
      sq_sum <= sq_re + sq_im;
    end
    if (ld.ld4) begin
      power <= power_next;
    end
  end

endmodule

// ===== hdl/sba_blend.sv =====
// ----------------------------------------------------------------------------
// sba_blend
// Attack/release blend: level + ((power - level) * alpha) >> 16, floored,
// which equals (power*a + level*(65536-a)) >> 16.
// ----------------------------------------------------------------------------
module sba_blend import sba_pkg::*; (
  input  logic               clk,
  input  sba_load_t          ld,
  input  logic [LEVEL_W-1:0] power,
  input  logic [LEVEL_W-1:0] old_level,
  input  logic [ALPHA_W-1:0] attack_alpha,
  input  logic [ALPHA_W-1:0] release_alpha,
  output logic [LEVEL_W-1:0] new_level
);

  logic signed [LEVEL_W:0]   diff;
  logic signed [LEVEL_W:0]   diff_next;
  logic [ALPHA_W-1:0]        alpha;
  logic [LEVEL_W-1:0]        old5;
  logic signed [PROD_W-1:0]  prod;
  logic [LEVEL_W-1:0]        old6;

  assign diff_next = signed'({1'b0, power}) - signed'({1'b0, old_level});
  assign new_level = old6 + prod[LEVEL_W+ALPHA_W-1:ALPHA_W];

  always_ff @(posedge clk) begin
    if (ld.ld5) begin
      diff  <= diff_next;
      alpha <= diff_next[LEVEL_W] ? release_alpha : attack_alpha;
      old5  <= old_level;
    end
    if (ld.ld6) begin
      prod <= PROD_W'(diff) * PROD_W'(signed'({1'b0, alpha}));
      old6 <= old5;
    end
  end

endmodule

// ===== hdl/spectrum_bin_attack_release_averager_core.sv =====
// ----------------------------------------------------------------------------
// spectrum_bin_attack_release_averager_core
// Smooths the power of each FFT bin with separate attack and release weights.
//
// One bin is taken per cycle while no stall holds the pipeline, and its
// level leaves the output register, held there until the sink is ready.
// The level store is one memory read a cycle and written a cycle; when a
// store address repeats within the three bins before it, the read waits
// for the earlier update to reach the write port. After reset a clearing
// pass sets every entry to one, one entry a cycle, during which no bin is
// taken; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module spectrum_bin_attack_release_averager_core import sba_pkg::*; #(
  parameter int BINS = DEFAULT_BINS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  sba_bin_if.sink                bin_stream,
  sba_level_if.source            level_stream
);

  localparam int ADDR_W = $clog2(BINS);

  logic [SHIFT_W-1:0] power_shift;
  logic [ALPHA_W-1:0] attack_alpha;
  logic [ALPHA_W-1:0] release_alpha;

  logic v1, v2, v3, v4, v5, v6, out_valid;
  logic adv1, adv2, adv3, adv4, adv5, adv6;
  logic free1, free2, free3, free4, free5, free6, free_out;
  logic hazard;
  logic accept;
  sba_load_t ld;

  logic [BIN_W-1:0]  bin1, bin2, bin3, bin4, bin5, bin6, out_bin;
  logic [ADDR_W-1:0] addr_d, addr2, addr3, addr4, addr5, addr6;

  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;

  logic [LEVEL_W-1:0] power;
  logic [LEVEL_W-1:0] old_level;
  logic [LEVEL_W-1:0] new_level;
  logic [LEVEL_W-1:0] level;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [LEVEL_W-1:0] ram_wdata;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      power_shift   <= POWER_SHIFT_RESET;
      attack_alpha  <= ATTACK_ALPHA_RESET;
      release_alpha <= RELEASE_ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POWER_SHIFT:   power_shift   <= cfg_data[SHIFT_W-1:0];
        REG_ATTACK_ALPHA:  attack_alpha  <= cfg_data[ALPHA_W-1:0];
        REG_RELEASE_ALPHA: release_alpha <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow
  assign free_out = !out_valid || level_stream.ready;
  assign adv6     = v6 && free_out;
  assign free6    = !v6 || adv6;
  assign adv5     = v5 && free6;
  assign free5    = !v5 || adv5;
  assign adv4     = v4 && free5;
  assign free4    = !v4 || adv4;
  assign hazard   = (v4 && addr4 == addr3) || (v5 && addr5 == addr3) ||
                    (v6 && !adv6 && addr6 == addr3);
  assign adv3     = v3 && free4 && !hazard;
  assign free3    = !v3 || adv3;
  assign adv2     = v2 && free3;
  assign free2    = !v2 || adv2;
  assign adv1     = v1 && free2;
  assign free1    = !v1 || adv1;

  assign bin_stream.ready = free1 && !clr_busy;
  assign accept           = bin_stream.valid && bin_stream.ready;

  assign ld = '{ld1: accept, ld2: adv1, ld3: adv2, ld4: adv3,
                ld5: adv4, ld6: adv5, ld_out: adv6};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= ld.ld1 || (v1 && !adv1);
      v2        <= ld.ld2 || (v2 && !adv2);
      v3        <= ld.ld3 || (v3 && !adv3);
      v4        <= ld.ld4 || (v4 && !adv4);
      v5        <= ld.ld5 || (v5 && !adv5);
      v6        <= ld.ld6 || (v6 && !adv6);
      out_valid <= ld.ld_out || (out_valid && !level_stream.ready);
    end
  end

  // store address: bin number modulo BINS
  if (BINS >= (1 << BIN_W)) begin : g_wide
    assign addr_d = ADDR_W'(bin1);
  end else if ((BINS & (BINS - 1)) == 0) begin : g_pow2
    assign addr_d = bin1[ADDR_W-1:0];
  end else begin : g_recip
    localparam int RECIP = (1 << BIN_W) / BINS;
    localparam logic [BIN_W:0] BINS_C = (BIN_W + 1)'(BINS);
    logic [BIN_W-1:0] quot;
    logic [BIN_W-1:0] quot_next;
    logic [BIN_W:0]   rem;

    assign quot_next = BIN_W'(((2 * BIN_W)'(bin_stream.bin_index) *
                               (2 * BIN_W)'(RECIP)) >> BIN_W);
    assign rem       = {1'b0, bin1} - (BIN_W + 1)'(int'(quot) * BINS);
    assign addr_d    = (rem >= BINS_C) ? ADDR_W'(rem - BINS_C) : ADDR_W'(rem);

    always_ff @(posedge clk) begin
      if (ld.ld1) begin
        quot <= quot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.ld1) bin1 <= bin_stream.bin_index;
    if (ld.ld2) begin
      bin2  <= bin1;
      addr2 <= addr_d;
    end
    if (ld.ld3) begin
      bin3  <= bin2;
      addr3 <= addr2;
    end
    if (ld.ld4) begin
      bin4  <= bin3;
      addr4 <= addr3;
    end
    if (ld.ld5) begin
      bin5  <= bin4;
      addr5 <= addr4;
    end
    if (ld.ld6) begin
      bin6  <= bin5;
      addr6 <= addr5;
    end
    if (ld.ld_out) begin
      out_bin <= bin6;
      level   <= new_level;
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(BINS - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_busy || adv6;
  assign ram_waddr = clr_busy ? clr_addr : addr6;
  assign ram_wdata = clr_busy ? LEVEL_FLOOR : new_level;

  sba_power u_power (
    .clk         (clk),
    .ld          (ld),
    .real_part   (bin_stream.real_part),
    .imag_part   (bin_stream.imag_part),
    .power_shift (power_shift),
    .power       (power)
  );

  sba_level_ram #(
    .DEPTH (BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (adv3),
    .raddr (addr3),
    .rdata (old_level)
  );

  sba_blend u_blend (
    .clk           (clk),
    .ld            (ld),
    .power         (power),
    .old_level     (old_level),
    .attack_alpha  (attack_alpha),
    .release_alpha (release_alpha),
    .new_level     (new_level)
  );

  assign level_stream.valid   = out_valid;
  assign level_stream.out_bin = out_bin;
  assign level_stream.level   = level;

endmodule
